FILE: hdl/adcs_pkg.sv
// Shared types and constants for the axis deadzone curve shaper.
// No dependencies; every other file in hdl/ uses this package.
`timescale 1ns / 1ps

package adcs_pkg;

   // Axis kind codes carried with each request
   localparam logic [1:0] OP_STICK_X = 2'd0;
   localparam logic [1:0] OP_STICK_Y = 2'd1;
   localparam logic [1:0] OP_TRIGGER = 2'd2;

   // Response curve codes; the unused code behaves as quadratic
   localparam logic [1:0] CURVE_LINEAR = 2'd0;
   localparam logic [1:0] CURVE_QUAD   = 2'd1;
   localparam logic [1:0] CURVE_CUBIC  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_STICK_DZ   = 3'd0;
   localparam logic [2:0] CSR_CURVE      = 3'd1;
   localparam logic [2:0] CSR_FLIP_X     = 3'd2;
   localparam logic [2:0] CSR_FLIP_Y     = 3'd3;
   localparam logic [2:0] CSR_TRIGGER_DZ = 3'd4;

   // Q1.16 one
   localparam logic [16:0] Q_ONE = 17'h10000;

   // Divider shape: one leading quotient bit, then two bits per stage
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = 8;

   typedef struct packed {
      logic [16:0] stick_dz;
      logic [1:0]  curve;
      logic        flip_x;
      logic        flip_y;
      logic [16:0] trigger_dz;
   } cfg_type;

   // Control that travels alongside the datapath
   typedef struct packed {
      logic       valid;
      logic       neg;
      logic       zero;
      logic [1:0] curve;
   } side_type;

endpackage

FILE: hdl/adcs_front.sv
// Normalization and deadzone preparation: two pipeline stages.
// Depends on adcs_pkg; feeds numerator and denominator to adcs_div.
`timescale 1ns / 1ps

module adcs_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [1:0]            in_opcode,
   input  logic [15:0]           in_raw,
   input  adcs_pkg::cfg_type     cfg,
   output adcs_pkg::side_type    out_side,
   output logic [16:0]           out_num,
   output logic [16:0]           out_den
);

   // Trigger scaling thresholds: 2a / 32767 gives 0, 1 or 2
   localparam logic [16:0] TRIG_ONE = 17'd32767;
   localparam logic [16:0] TRIG_TWO = 17'd65534;

   logic        raw_neg;
   logic [15:0] abs_val;
   logic [16:0] twice;
   logic [16:0] trig_mag;

   logic [16:0] mag_in, mag_ff;
   logic [16:0] dz_in, dz_ff;
   logic [1:0]  curve_in, curve_ff;
   logic        neg_in, neg_ff;
   logic        bad_in, bad_ff;
   logic        valid_a_ff;

   adcs_pkg::side_type side_in, side_ff;
   logic [16:0] num_in, num_ff;
   logic [16:0] den_in, den_ff;

   // Stage A: magnitude, sign and per-axis settings
   always_comb begin
      raw_neg  = in_raw[15];
      abs_val  = raw_neg ? (~in_raw + 16'd1) : in_raw;
      twice    = {abs_val, 1'b0};
      // floor(a * 65536 / 32767) = 2a + floor(2a / 32767)
      if (twice >= TRIG_TWO) begin
         trig_mag = twice + 17'd2;
      end else if (twice >= TRIG_ONE) begin
         trig_mag = twice + 17'd1;
      end else begin
         trig_mag = twice;
      end
      if (raw_neg) begin
         trig_mag = '0;
      end

      mag_in   = '0;
      dz_in    = '0;
      curve_in = adcs_pkg::CURVE_LINEAR;
      neg_in   = 1'b0;
      bad_in   = 1'b0;
      case (in_opcode)
         adcs_pkg::OP_STICK_X: begin
            mag_in   = twice;
            dz_in    = cfg.stick_dz;
            curve_in = cfg.curve;
            neg_in   = raw_neg ^ cfg.flip_x;
         end
         adcs_pkg::OP_STICK_Y: begin
            mag_in   = twice;
            dz_in    = cfg.stick_dz;
            curve_in = cfg.curve;
            neg_in   = raw_neg ^ cfg.flip_y;
         end
         adcs_pkg::OP_TRIGGER: begin
            mag_in = trig_mag;
            dz_in  = cfg.trigger_dz;
         end
         default: begin
            bad_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      mag_ff   <= mag_in;
      dz_ff    <= dz_in;
      curve_ff <= curve_in;
      neg_ff   <= neg_in;
      bad_ff   <= bad_in;
   end

   // Stage B: deadzone test, offset magnitude and rescale denominator
   always_comb begin
      side_in.valid = valid_a_ff;
      side_in.neg   = neg_ff;
      side_in.curve = curve_ff;
      side_in.zero  = bad_ff | dz_ff[16] | (mag_ff < dz_ff);
      num_in        = mag_ff - dz_ff;
      den_in        = adcs_pkg::Q_ONE - dz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else begin
         side_ff <= side_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
   end

   assign out_side = side_ff;
   assign out_num  = num_ff;
   assign out_den  = den_ff;

endmodule

FILE: hdl/adcs_div.sv
// Pipelined restoring divider for the deadzone rescale: (num << 16) / den.
// Depends on adcs_pkg; num <= den whenever zero is clear, so the quotient fits 17 bits.
`timescale 1ns / 1ps

module adcs_div (
   input  logic                  clock,
   input  logic                  reset,
   input  adcs_pkg::side_type    in_side,
   input  logic [16:0]           in_num,
   input  logic [16:0]           in_den,
   output adcs_pkg::side_type    out_side,
   output logic [16:0]           out_quot
);

   localparam int LAST = adcs_pkg::DIV_STAGES;

   adcs_pkg::side_type side_ff [0:LAST];
   logic [16:0]        rem_ff  [0:LAST];
   logic [16:0]        den_ff  [0:LAST];
   logic [16:0]        quot_ff [0:LAST];

   // One shift-and-subtract step; returns {quotient bit, new remainder}
   function automatic logic [17:0] div_step(input logic [16:0] rem,
                                            input logic [16:0] den);
      logic [17:0] shifted;
      logic [17:0] diff;
      shifted = {rem, 1'b0};
      diff    = shifted - {1'b0, den};
      if (shifted >= {1'b0, den}) begin
         div_step = {1'b1, diff[16:0]};
      end else begin
         div_step = {1'b0, shifted[16:0]};
      end
   endfunction

   // Leading stage: the top quotient bit is set when num >= den (for a live sample, num equals den)
   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff[0] <= '0;
      end else begin
         side_ff[0] <= in_side;
      end
      den_ff[0] <= in_den;
      if (in_num >= in_den) begin
         rem_ff[0]  <= in_num - in_den;
         quot_ff[0] <= adcs_pkg::Q_ONE;
      end else begin
         rem_ff[0]  <= in_num;
         quot_ff[0] <= '0;
      end
   end

   // Remaining stages: two quotient bits each, high bits first
   for (genvar k = 1; k <= LAST; k++) begin : g_stage
      localparam int HI = 16 - (k - 1) * adcs_pkg::DIV_BITS_PER_STAGE - 1;

      logic [17:0] step_a;
      logic [17:0] step_b;
      logic [16:0] quot_in;

      always_comb begin
         step_a  = div_step(rem_ff[k-1], den_ff[k-1]);
         step_b  = div_step(step_a[16:0], den_ff[k-1]);
         quot_in = quot_ff[k-1];
         quot_in[HI]     = step_a[17];
         quot_in[HI - 1] = step_b[17];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[k] <= '0;
         end else begin
            side_ff[k] <= side_ff[k-1];
         end
         den_ff[k]  <= den_ff[k-1];
         rem_ff[k]  <= step_b[16:0];
         quot_ff[k] <= quot_in;
      end
   end

   assign out_side = side_ff[LAST];
   assign out_quot = quot_ff[LAST];

endmodule

FILE: hdl/adcs_curve.sv
// Response curve, output scaling by 32767 and sign restore: three stages.
// Depends on adcs_pkg; takes the rescaled magnitude from adcs_div.
`timescale 1ns / 1ps

module adcs_curve (
   input  logic                  clock,
   input  logic                  reset,
   input  adcs_pkg::side_type    in_side,
   input  logic [16:0]           in_s,
   output logic                  out_valid,
   output logic signed [15:0]    out_value
);

   adcs_pkg::side_type side1_ff, side2_ff;
   logic [33:0] sq_in, sq_ff;
   logic [16:0] s1_ff;
   logic [50:0] cube;
   logic [16:0] c_in, c_ff;
   logic [31:0] prod;
   logic [15:0] mag16;
   logic [15:0] value_in;
   logic        valid_ff;
   logic [15:0] value_ff;

   // Stage 1: square
   assign sq_in = 34'(in_s) * 34'(in_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
      end else begin
         side1_ff <= in_side;
      end
      sq_ff <= sq_in;
      s1_ff <= in_s;
   end

   // Stage 2: cube and curve select
   always_comb begin
      cube = 51'(sq_ff) * 51'(s1_ff);
      case (side1_ff.curve)
         adcs_pkg::CURVE_LINEAR: c_in = s1_ff;
         adcs_pkg::CURVE_CUBIC:  c_in = cube[48:32];
         default:                c_in = sq_ff[32:16];
      endcase
      if (side1_ff.zero) begin
         c_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side2_ff <= '0;
      end else begin
         side2_ff <= side1_ff;
      end
      c_ff <= c_in;
   end

   // Stage 3: c * 32767 / 65536 (never above 32767), then the sign
   always_comb begin
      prod     = {c_ff, 15'd0} - {15'd0, c_ff};
      mag16    = prod[31:16];
      value_in = side2_ff.neg ? (~mag16 + 16'd1) : mag16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side2_ff.valid;
      end
      value_ff <= value_in;
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

FILE: hdl/axis_deadzone_curve_shaper.sv
// Top level of the axis deadzone curve shaper: request capture, control
// registers and the pipeline. Depends on adcs_pkg, adcs_front, adcs_div, adcs_curve.
//
//   Port group   Direction  Handshake              Carries
//   request      in         start / busy           req_opcode, req_raw_value
//   response     out        rsp_valid (strobe)     rsp_shaped_value
//   csr          in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One request is taken every cycle while busy is low; busy is high only during reset and the cycle after it.
// Each response strobes after its request has passed through the input
// register, two normalize stages, nine divider stages and three curve/scale stages.
// Reset is synchronous and clears the valid pipeline and the control registers.
// The response side has no back-pressure, so the pipeline never stalls.
// csr_ready is always high; writes are expected only while the pipeline is empty.
`timescale 1ns / 1ps

module axis_deadzone_curve_shaper (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic signed [15:0]  req_raw_value,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_shaped_value,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [16:0]         csr_wdata
);

   adcs_pkg::cfg_type  cfg_ff;
   logic               busy_in, busy_ff;
   logic               req_valid_in, req_valid_ff;
   logic [1:0]         req_opcode_ff;
   logic [15:0]        req_raw_ff;

   adcs_pkg::side_type front_side;
   logic [16:0]        front_num;
   logic [16:0]        front_den;
   adcs_pkg::side_type div_side;
   logic [16:0]        div_quot;

   assign csr_ready = 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stick_dz   <= '0;
         cfg_ff.curve      <= adcs_pkg::CURVE_QUAD;
         cfg_ff.flip_x     <= 1'b0;
         cfg_ff.flip_y     <= 1'b0;
         cfg_ff.trigger_dz <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            adcs_pkg::CSR_STICK_DZ:   cfg_ff.stick_dz   <= csr_wdata;
            adcs_pkg::CSR_CURVE:      cfg_ff.curve      <= csr_wdata[1:0];
            adcs_pkg::CSR_FLIP_X:     cfg_ff.flip_x     <= csr_wdata[0];
            adcs_pkg::CSR_FLIP_Y:     cfg_ff.flip_y     <= csr_wdata[0];
            adcs_pkg::CSR_TRIGGER_DZ: cfg_ff.trigger_dz <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request capture; busy only holds off the cycle right after reset
   assign busy_in      = reset;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_opcode_ff <= req_opcode;
      req_raw_ff    <= req_raw_value;
   end

   assign busy = busy_ff;

   adcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_opcode (req_opcode_ff),
      .in_raw    (req_raw_ff),
      .cfg       (cfg_ff),
      .out_side  (front_side),
      .out_num   (front_num),
      .out_den   (front_den)
   );

   adcs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_side  (front_side),
      .in_num   (front_num),
      .in_den   (front_den),
      .out_side (div_side),
      .out_quot (div_quot)
   );

   adcs_curve u_curve (
      .clock     (clock),
      .reset     (reset),
      .in_side   (div_side),
      .in_s      (div_quot),
      .out_valid (rsp_valid),
      .out_value (rsp_shaped_value)
   );

endmodule
